// ----- rtl/core/chema_pkg.sv -----
`default_nettype none
package chema_pkg;

  localparam int SampleBitsDef = 16;
  localparam int AngleItersDef = 16;
  localparam int TableLen      = 20;
  localparam int QueueDepth    = 2;

  localparam logic [15:0] AlphaReset  = 16'd9830;
  localparam logic [31:0] WindowReset = 32'd15000;

  typedef enum logic [0:0] {
    CFG_EMA_ALPHA = 1'b0,
    CFG_WINDOW    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [17:0] re;
    logic signed [17:0] im;
    logic               calibrating;
    logic               calibrated;
    logic               cal_done;
    logic signed [16:0] off_x;
    logic signed [16:0] off_y;
    logic signed [16:0] off_z;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_VEC,
    BK_ROT,
    BK_QNT,
    BK_MUL,
    BK_ADD,
    BK_LD2,
    BK_OUT
  } back_state_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/compass_heading_hard_iron_ema_top.sv -----
`default_nettype none
// channel   dir  handshake              payload
// s_axis    in   s_tvalid / s_tready    s_tdata, s_tuser
// m_axis    out  m_tvalid / m_tready    m_tdata
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front takes one beat per cycle, while the queue has room, into a
// two-entry queue and updates the calibration state there. The back runs one
// item at a time: vectoring pass, rotation pass, EMA multiply and add,
// second vectoring pass; the two vectoring passes share one CORDIC datapath.
// Reset is synchronous; results hold in the output register until taken.
module compass_heading_hard_iron_ema_top #(
  parameter int SAMPLE_BITS      = chema_pkg::SampleBitsDef,
  parameter int ANGLE_ITERATIONS = chema_pkg::AngleItersDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // mag_x, mag_y, mag_z, time_ms
  input  wire logic        s_tuser,   // action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // heading, calibrating, calibrated, cal_done,
                                      // offset_x_twice, offset_y_twice,
                                      // offset_z_twice, zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import chema_pkg::*;

  logic [15:0] ema_alpha;
  logic [31:0] cal_window_ms;
  logic        f_valid;
  logic        f_ready;
  item_t       f_item;
  logic        b_valid;
  logic        b_ready;
  item_t       b_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ema_alpha     <= AlphaReset;
      cal_window_ms <= WindowReset;
    end else if (cfg_valid && cfg_index[7:1] == '0) begin
      unique case (cfg_reg_t'(cfg_index[0]))
        CFG_EMA_ALPHA: ema_alpha     <= cfg_data[15:0];
        CFG_WINDOW:    cal_window_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  chema_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .action(s_tuser),
    .mag_x(s_tdata[15:0]), .mag_y(s_tdata[31:16]), .mag_z(s_tdata[47:32]),
    .time_ms(s_tdata[79:48]),
    .cal_window_ms,
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  chema_fifo u_fifo (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
  );

  chema_back #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_back (
    .clk, .rst,
    .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .ema_alpha,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
  );

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    !f_ready |-> !s_tready) else $error("front accepts into full queue");

  a_done_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[17] && !m_tdata[16])
    else $error("cal_done without calibrated state");

  a_queue_to_back: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_ready |=> !b_ready) else $error("back took two items in a row");

endmodule
`default_nettype wire

// ----- rtl/core/chema_front.sv -----
`default_nettype none
module chema_front #(
  parameter int SAMPLE_BITS = chema_pkg::SampleBitsDef
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                action,
  input  wire logic [15:0]         mag_x,
  input  wire logic [15:0]         mag_y,
  input  wire logic [15:0]         mag_z,
  input  wire logic [31:0]         time_ms,
  input  wire logic [31:0]         cal_window_ms,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output chema_pkg::item_t         q_item
);
  import chema_pkg::*;

  logic signed [15:0] m [3];
  logic signed [15:0] axis_min [3];
  logic signed [15:0] axis_max [3];
  logic signed [15:0] min_next [3];
  logic signed [15:0] max_next [3];
  logic signed [16:0] offs [3];
  logic               collecting;
  logic               has_cal;
  logic [31:0]        window_start;
  logic               start;
  logic               coll_mid;
  logic [31:0]        ws_next;
  logic               finish;
  logic               take;

  always_comb begin
    m[0] = 16'(signed'(mag_x[SAMPLE_BITS-1:0]));
    m[1] = 16'(signed'(mag_y[SAMPLE_BITS-1:0]));
    m[2] = 16'(signed'(mag_z[SAMPLE_BITS-1:0]));
    start    = action && !collecting;
    coll_mid = collecting || start;
    ws_next  = start ? time_ms : window_start;
    for (int k = 0; k < 3; k++) begin
      min_next[k] = start ? m[k] : axis_min[k];
      max_next[k] = start ? m[k] : axis_max[k];
      if (coll_mid && m[k] < min_next[k]) min_next[k] = m[k];
      if (coll_mid && m[k] > max_next[k]) max_next[k] = m[k];
    end
    finish = coll_mid && ((time_ms - ws_next) >= cal_window_ms);
  end

  assign in_ready = q_ready;
  assign take     = in_valid && in_ready;
  assign q_valid  = in_valid;

  always_comb begin
    q_item.re          = 18'(signed'({m[1], 1'b0})) - 18'(offs[1]);
    q_item.im          = 18'(signed'({m[0], 1'b0})) - 18'(offs[0]);
    q_item.calibrating = coll_mid && !finish;
    q_item.calibrated  = has_cal || finish;
    q_item.cal_done    = finish;
    q_item.off_x       = finish ? 17'(max_next[0]) + 17'(min_next[0]) : offs[0];
    q_item.off_y       = finish ? 17'(max_next[1]) + 17'(min_next[1]) : offs[1];
    q_item.off_z       = finish ? 17'(max_next[2]) + 17'(min_next[2]) : offs[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting   <= 1'b0;
      has_cal      <= 1'b0;
      window_start <= '0;
      for (int k = 0; k < 3; k++) begin
        axis_min[k] <= '0;
        axis_max[k] <= '0;
        offs[k]     <= '0;
      end
    end else if (take) begin
      collecting   <= coll_mid && !finish;
      has_cal      <= has_cal || finish;
      window_start <= ws_next;
      for (int k = 0; k < 3; k++) begin
        axis_min[k] <= min_next[k];
        axis_max[k] <= max_next[k];
      end
      offs[0] <= q_item.off_x;
      offs[1] <= q_item.off_y;
      offs[2] <= q_item.off_z;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/chema_fifo.sv -----
`default_nettype none
module chema_fifo (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_valid,
  output logic            wr_ready,
  input  wire chema_pkg::item_t wr_item,
  output logic            rd_valid,
  input  wire logic       rd_ready,
  output chema_pkg::item_t rd_item
);
  import chema_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  item_t           mem [QueueDepth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [PtrW:0]   count;
  logic            push;
  logic            pop;

  assign wr_ready = count != (PtrW+1)'(QueueDepth);
  assign rd_valid = count != '0;
  assign rd_item  = mem[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PtrW'(QueueDepth - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PtrW'(QueueDepth - 1)) ? '0 : rptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/chema_back.sv -----
`default_nettype none
module chema_back #(
  parameter int ANGLE_ITERATIONS = chema_pkg::AngleItersDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire chema_pkg::item_t q_item,
  input  wire logic [15:0] ema_alpha,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [71:0]      out_data
);
  import chema_pkg::*;

  localparam logic [4:0] LastIter = 5'(ANGLE_ITERATIONS - 1);
  localparam logic signed [33:0] RotGain = 34'sd652032874;

  back_state_t        state;
  back_state_t        state_next;
  item_t              held;
  logic               pass2;
  logic               zflag;
  logic [4:0]         cnt;
  logic signed [35:0] vr;
  logic signed [35:0] vi;
  logic [31:0]        ang;
  logic [31:0]        vec_ang;
  logic signed [33:0] rx;
  logic signed [33:0] ry;
  logic signed [33:0] rz;
  logic               flip;
  logic signed [17:0] raw_s;
  logic signed [17:0] raw_c;
  logic signed [17:0] sm_s;
  logic signed [17:0] sm_c;
  logic signed [35:0] pa_s;
  logic signed [35:0] pb_s;
  logic signed [35:0] pa_c;
  logic signed [35:0] pb_c;
  logic               last;
  logic               rot_flip;
  logic [31:0]        rot_r;
  logic signed [17:0] ld_re;
  logic signed [17:0] ld_im;
  logic signed [35:0] ld_vr;
  logic signed [35:0] ld_vi;
  logic signed [33:0] fx;
  logic signed [33:0] fy;
  logic signed [17:0] alpha_s;
  logic signed [17:0] beta_s;
  logic signed [36:0] sum_s;
  logic signed [36:0] sum_c;
  logic [31:0]        head_r;

  function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd8192) >>> 14;
    if (r > 34'sd65536) r = 34'sd65536;
    if (r < -34'sd65536) r = -34'sd65536;
    return 18'(r);
  endfunction

  assign last = zflag || (cnt == LastIter);

  always_comb begin
    ld_re = (state == BK_IDLE) ? q_item.re : sm_c;
    ld_im = (state == BK_IDLE) ? q_item.im : sm_s;
    ld_vr = 36'(ld_re) <<< 14;
    ld_vi = 36'(ld_im) <<< 14;
    vec_ang = zflag ? '0 : (vi > 0) ? ang + atan_turn(cnt) : ang - atan_turn(cnt);
    rot_flip = (vec_ang - 32'h4000_0000) < 32'h8000_0000;
    rot_r    = rot_flip ? vec_ang - 32'h8000_0000 : vec_ang;
    fx = flip ? -rx : rx;
    fy = flip ? -ry : ry;
    alpha_s = 18'({2'b00, ema_alpha});
    beta_s  = 18'sd65536 - alpha_s;
    sum_s = 37'(pa_s) + 37'(pb_s) + 37'sd32768;
    sum_c = 37'(pa_c) + 37'(pb_c) + 37'sd32768;
    head_r = ang + 32'h0000_8000;
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = BK_VEC;
      end
      BK_VEC: if (last) state_next = pass2 ? BK_OUT : BK_ROT;
      BK_ROT: if (cnt == LastIter) state_next = BK_QNT;
      BK_QNT: state_next = BK_MUL;
      BK_MUL: state_next = BK_ADD;
      BK_ADD: state_next = BK_LD2;
      BK_LD2: state_next = BK_VEC;
      BK_OUT: if (!out_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE, BK_LD2: begin
        if (state == BK_IDLE) held <= q_item;
        pass2 <= (state == BK_LD2);
        cnt   <= '0;
        zflag <= (ld_re == '0) && (ld_im == '0);
        if (ld_re < 0) begin
          vr  <= -ld_vr;
          vi  <= -ld_vi;
          ang <= 32'h8000_0000;
        end else begin
          vr  <= ld_vr;
          vi  <= ld_vi;
          ang <= '0;
        end
      end
      BK_VEC: begin
        if (zflag) begin
          ang <= '0;
        end else if (vi > 0) begin
          vr  <= vr + (vi >>> cnt);
          vi  <= vi - (vr >>> cnt);
          ang <= ang + atan_turn(cnt);
        end else begin
          vr  <= vr - (vi >>> cnt);
          vi  <= vi + (vr >>> cnt);
          ang <= ang - atan_turn(cnt);
        end
        cnt <= last ? '0 : cnt + 5'd1;
        if (last && !pass2) begin
          rx   <= RotGain;
          ry   <= '0;
          flip <= rot_flip;
          rz   <= 34'(signed'(rot_r));
        end
      end
      BK_ROT: begin
        cnt <= cnt + 5'd1;
      end
      default: begin
      end
    endcase

    if (state == BK_ROT) begin
      if (rz >= 0) begin
        rx <= rx - (ry >>> cnt);
        ry <= ry + (rx >>> cnt);
        rz <= rz - 34'(atan_turn(cnt));
      end else begin
        rx <= rx + (ry >>> cnt);
        ry <= ry - (rx >>> cnt);
        rz <= rz + 34'(atan_turn(cnt));
      end
    end
    if (state == BK_QNT) begin
      raw_s <= to_q16(fy);
      raw_c <= to_q16(fx);
    end
    if (state == BK_MUL) begin
      pa_s <= alpha_s * raw_s;
      pb_s <= beta_s * sm_s;
      pa_c <= alpha_s * raw_c;
      pb_c <= beta_s * sm_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_s <= '0;
      sm_c <= 18'sd65536;
    end else if (state == BK_ADD) begin
      sm_s <= 18'(sum_s >>> 16);
      sm_c <= 18'(sum_c >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == BK_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_OUT && (!out_valid || out_ready)) begin
      out_data <= {2'b00, held.off_z, held.off_y, held.off_x, held.cal_done,
                   held.calibrated, held.calibrating, head_r[31:16]};
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/compass_heading_hard_iron_ema_top_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module compass_heading_hard_iron_ema_top_test;
  import chema_pkg::*;

  localparam int  Iters     = 16;
  localparam int  CfgUnused = 2;
  localparam longint RotGain = 652032874;
  localparam logic [31:0] HalfTurn    = 32'h80000000;
  localparam logic [31:0] QuarterTurn = 32'h40000000;

  localparam logic [31:0] TurnStep [Iters] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D
  };

  typedef struct {
    logic [15:0] heading;
    logic        calibrating;
    logic        calibrated;
    logic        cal_done;
    logic [16:0] off_x;
    logic [16:0] off_y;
    logic [16:0] off_z;
  } heading_out_t;

  typedef struct {
    bit          act;
    int          x;
    int          y;
    int          z;
    logic [31:0] t;
    bit          pin;
    logic [2:0]  flags; // calibrating, calibrated, cal_done
  } sample_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;  // mag_x, mag_y, mag_z, time_ms
  logic        s_tuser = 1'b0; // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;       // heading, calibrating, calibrated, cal_done,
                              // offset_x_twice, offset_y_twice, offset_z_twice
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #2 clk = ~clk;

  compass_heading_hard_iron_ema_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // compass model state
  logic [15:0] alpha;
  logic [31:0] window_ms;
  longint      sm_sin, sm_cos;
  longint      axis_lo [3];
  longint      axis_hi [3];
  longint      off_sum [3];
  bit          collecting, have_cal;
  logic [31:0] win_start;

  heading_out_t expected_headings[$];
  int          mismatches = 0;
  int          burst_left = 0;

  function automatic logic [31:0] turn_of(longint re, longint im);
    logic [31:0] ang;
    longint dr, di;
    if (re == 0 && im == 0) return '0;
    re = re * 16384;
    im = im * 16384;
    ang = '0;
    if (re < 0) begin
      re = -re;
      im = -im;
      ang = HalfTurn;
    end
    for (int i = 0; i < Iters; i++) begin
      dr = im >>> i;
      di = re >>> i;
      if (im > 0) begin
        re += dr; im -= di; ang += TurnStep[i];
      end else begin
        re -= dr; im += di; ang -= TurnStep[i];
      end
    end
    return ang;
  endfunction

  function automatic longint round_q16(longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > 65536) r = 65536;
    if (r < -65536) r = -65536;
    return r;
  endfunction

  function automatic longint blend(longint fresh, longint old);
    longint a;
    a = longint'(alpha);
    return (a * fresh + (65536 - a) * old + 32768) >>> 16;
  endfunction

  task automatic step_compass(input bit act, input logic [79:0] d,
                              output heading_out_t o);
    longint m [3];
    longint x, y, z, dx, dy, s, c;
    logic [31:0] now, r, head;
    bit flip, done;
    m[0] = longint'($signed(d[15:0]));
    m[1] = longint'($signed(d[31:16]));
    m[2] = longint'($signed(d[47:32]));
    now = d[79:48];
    done = 1'b0;
    if (act && !collecting) begin
      for (int k = 0; k < 3; k++) begin
        axis_lo[k] = m[k];
        axis_hi[k] = m[k];
      end
      win_start = now;
      collecting = 1'b1;
    end
    if (collecting)
      for (int k = 0; k < 3; k++) begin
        if (m[k] < axis_lo[k]) axis_lo[k] = m[k];
        if (m[k] > axis_hi[k]) axis_hi[k] = m[k];
      end
    r = turn_of(2 * m[1] - off_sum[1], 2 * m[0] - off_sum[0]);
    flip = (r - QuarterTurn) < HalfTurn;
    if (flip) r = r - HalfTurn;
    z = longint'($signed(r));
    x = RotGain;
    y = 0;
    for (int i = 0; i < Iters; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(TurnStep[i]);
      end else begin
        x += dx; y -= dy; z += longint'(TurnStep[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = round_q16(x);
    s = round_q16(y);
    sm_sin = blend(s, sm_sin);
    sm_cos = blend(c, sm_cos);
    head = turn_of(sm_cos, sm_sin);
    if (collecting && (now - win_start) >= window_ms) begin
      for (int k = 0; k < 3; k++) off_sum[k] = axis_hi[k] + axis_lo[k];
      have_cal = 1'b1;
      collecting = 1'b0;
      done = 1'b1;
    end
    head = head + 32'h8000;
    o.heading     = head[31:16];
    o.calibrating = collecting;
    o.calibrated  = have_cal;
    o.cal_done    = done;
    o.off_x       = off_sum[0][16:0];
    o.off_y       = off_sum[1][16:0];
    o.off_z       = off_sum[2][16:0];
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_sample(input bit act, input logic [79:0] d, input bit pin,
                             input logic [2:0] flags);
    heading_out_t o;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    step_compass(act, d, o);
    if (pin) {o.calibrating, o.calibrated, o.cal_done} = flags;
    expected_headings.push_back(o);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_headings.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == 8'(CFG_EMA_ALPHA)) alpha = val[15:0];
    else if (idx == 8'(CFG_WINDOW)) window_ms = val;
  endtask

  function automatic logic [79:0] pack_sample(int x, int y, int z, logic [31:0] t);
    return {t, 16'(z), 16'(y), 16'(x)};
  endfunction

  sample_row_t rows [20] = '{
    '{0, 0, 0, 0, 32'd10, 1, 3'b000},
    '{0, 32767, -32768, 32767, 32'd20, 1, 3'b000},
    '{0, -32768, 32767, -32768, 32'd30, 1, 3'b000},
    '{0, 0, 100, 0, 32'd40, 1, 3'b000},
    '{1, 500, -300, 200, 32'd1000, 1, 3'b100},
    '{1, -32768, 32767, -1, 32'd2000, 1, 3'b100},
    '{0, 32767, -32768, 32767, 32'd15999, 1, 3'b100},
    '{0, 10, 10, 10, 32'd16000, 1, 3'b011},
    '{0, 1000, 0, 0, 32'd16010, 1, 3'b010},
    '{0, -5, 7, 0, 32'd16020, 1, 3'b010},
    '{1, 0, 0, 0, 32'hFFFFFF00, 1, 3'b110},
    '{0, 300, -200, 5, 32'd200, 1, 3'b110},
    '{0, -300, 200, -5, 32'd15000, 1, 3'b011},
    '{1, 1234, -4321, 7, 32'd5, 1, 3'b011},
    '{0, 0, 0, 0, 32'd6, 0, 3'b000},
    '{0, 2000, 2000, 0, 32'd7, 0, 3'b000},
    '{1, -32768, -32768, -32768, 32'd8, 1, 3'b011},
    '{1, 1, 1, 1, 32'd0, 1, 3'b110},
    '{0, 2, 2, 2, 32'hFFFFFFFE, 1, 3'b110},
    '{0, 3, 3, 3, 32'hFFFFFFFF, 1, 3'b011}
  };

  task automatic play_rows(input int first, input int last);
    for (int i = first; i <= last; i++)
      send_sample(rows[i].act, pack_sample(rows[i].x, rows[i].y, rows[i].z, rows[i].t),
                  rows[i].pin, rows[i].flags);
  endtask

  // receiver: check beats, stall in changing modes
  int stall_mode = 0;
  int stall_cnt  = 0;
  always @(posedge clk) begin
    heading_out_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_headings.size() == 0) begin
        $display("unexpected result beat %0h at %0t", m_tdata, $realtime);
        mismatches++;
      end else begin
        w = expected_headings.pop_front();
        if (m_tdata[15:0] !== w.heading)
          report("heading", 32'(m_tdata[15:0]), 32'(w.heading));
        if (m_tdata[16] !== w.calibrating)
          report("calibrating", 32'(m_tdata[16]), 32'(w.calibrating));
        if (m_tdata[17] !== w.calibrated)
          report("calibrated", 32'(m_tdata[17]), 32'(w.calibrated));
        if (m_tdata[18] !== w.cal_done)
          report("cal_done", 32'(m_tdata[18]), 32'(w.cal_done));
        if (m_tdata[35:19] !== w.off_x)
          report("offset_x_twice", 32'(m_tdata[35:19]), 32'(w.off_x));
        if (m_tdata[52:36] !== w.off_y)
          report("offset_y_twice", 32'(m_tdata[52:36]), 32'(w.off_y));
        if (m_tdata[69:53] !== w.off_z)
          report("offset_z_twice", 32'(m_tdata[69:53]), 32'(w.off_z));
      end
    end
    stall_cnt++;
    if (stall_cnt % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      2: m_tready <= (stall_cnt % 5 == 0);
      default: m_tready <= ((stall_cnt / 37) % 2 == 0);
    endcase
  end

  initial begin
    #20ms;
    $display("compass_heading_hard_iron_ema_top_test NOT OK");
    $finish;
  end

  initial begin
    logic [31:0] now;
    int cx, cy, cz, x, y, z, pick;
    alpha = AlphaReset;
    window_ms = WindowReset;
    sm_sin = 0;
    sm_cos = 65536;
    for (int k = 0; k < 3; k++) begin
      axis_lo[k] = 0; axis_hi[k] = 0; off_sum[k] = 0;
    end
    collecting = 1'b0;
    have_cal = 1'b0;
    win_start = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    play_rows(0, 12);
    drain();
    write_reg(8'(CFG_EMA_ALPHA), 32'd65535);
    write_reg(8'(CFG_WINDOW), 32'd0);
    play_rows(13, 14);
    drain();
    write_reg(8'(CFG_EMA_ALPHA), 32'd0);
    play_rows(15, 16);
    drain();
    write_reg(8'(CfgUnused), 32'hDEADBEEF);
    write_reg(8'(CFG_EMA_ALPHA), 32'hFFFF0000 | 32'd9830);
    write_reg(8'(CFG_WINDOW), 32'hFFFFFFFF);
    play_rows(17, 19);
    drain();

    now = $urandom;
    for (int ph = 0; ph < 10; ph++) begin
      pick = $urandom_range(0, 3);
      write_reg(8'(CFG_EMA_ALPHA), pick == 0 ? 32'd0 : pick == 1 ? 32'd65535 : $urandom);
      pick = $urandom_range(0, 5);
      write_reg(8'(CFG_WINDOW), pick == 0 ? 32'd0 : pick == 1 ? 32'hFFFFFFFF :
                                $urandom_range(1, 60));
      if ($urandom_range(0, 2) == 0) write_reg(8'($urandom_range(2, 255)), $urandom);
      cx = $urandom_range(0, 65535) - 32768;
      cy = $urandom_range(0, 65535) - 32768;
      cz = $urandom_range(0, 65535) - 32768;
      for (int n = 0; n < 65; n++) begin
        if ($urandom_range(0, 29) == 0) now = $urandom;
        else now = now + $urandom_range(0, 8);
        if ($urandom_range(0, 1) == 0) begin
          x = $urandom_range(0, 65535) - 32768;
          y = $urandom_range(0, 65535) - 32768;
          z = $urandom_range(0, 65535) - 32768;
        end else begin
          x = cx + $urandom_range(0, 4000) - 2000;
          y = cy + $urandom_range(0, 4000) - 2000;
          z = cz + $urandom_range(0, 4000) - 2000;
        end
        send_sample($urandom_range(0, 7) == 0, pack_sample(x, y, z, now), 1'b0, 3'b000);
      end
      drain();
    end

    if (mismatches == 0)
      $display("compass_heading_hard_iron_ema_top_test OK");
    else
      $display("compass_heading_hard_iron_ema_top_test NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

// ----- compass_heading_hard_iron_ema_top.f -----
rtl/core/chema_pkg.sv
rtl/core/chema_front.sv
rtl/core/chema_fifo.sv
rtl/core/chema_back.sv
rtl/core/compass_heading_hard_iron_ema_top.sv
tb/sv/compass_heading_hard_iron_ema_top_test.sv
